// ===== design/h2t_pkg.sv =====
// ----------------------------------------------------------------------------
// h2t_pkg
// Token type, match patterns and byte classes shared by the filter stages.
// ----------------------------------------------------------------------------
package h2t_pkg;

  typedef struct packed {
    logic [7:0] data;
    logic       eod;
    logic       fin;
  } tok_t;

  localparam int STR_W       = 80;
  localparam int BLK_HOLD    = 8;
  localparam int BLK_SCRIPT  = 0;
  localparam int BLK_STYLE   = 1;
  localparam int BLK_COMMENT = 2;
  localparam int NUM_ENT     = 6;
  localparam int ENT_MAXLEN  = 6;
  localparam int AMP_LEN     = 5;
  localparam int UTF8_HOLD   = 3;

  localparam logic [7:0] CH_AMP    = "&";
  localparam logic [7:0] CH_DASH   = "-";
  localparam logic [7:0] CH_LT     = "<";
  localparam logic [7:0] CH_GT     = ">";
  localparam logic [7:0] CH_SP     = " ";
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] ELL_B0    = 8'hE2;
  localparam logic [7:0] ELL_B1    = 8'h80;
  localparam logic [7:0] ELL_B2    = 8'hA6;
  localparam logic [7:0] UTF8_MASK = 8'hC0;
  localparam logic [7:0] UTF8_CONT = 8'h80;
  localparam logic [7:0] CASE_OFS  = 8'd32;
  localparam logic [15:0] MAX_LEN_RST = 16'd4000;

  function automatic logic [7:0] str_byte(input logic [STR_W-1:0] s, input int len,
                                          input int idx);
    logic [7:0] r;
    r = '0;
    if (idx >= 0 && idx < len) r = s[8*(len-1-idx) +: 8];
    return r;
  endfunction

  function automatic int blk_open_len(input int kind);
    case (kind)
      BLK_SCRIPT: return 7;
      BLK_STYLE:  return 6;
      default:    return 4;
    endcase
  endfunction

  function automatic int blk_close_len(input int kind);
    case (kind)
      BLK_SCRIPT: return 9;
      BLK_STYLE:  return 8;
      default:    return 3;
    endcase
  endfunction

  function automatic int blk_close_start(input int kind);
    case (kind)
      BLK_COMMENT: return 2;
      default:     return 0;
    endcase
  endfunction

  function automatic logic [7:0] blk_open_byte(input int kind, input int idx);
    case (kind)
      BLK_SCRIPT: return str_byte("<script", 7, idx);
      BLK_STYLE:  return str_byte("<style", 6, idx);
      default:    return str_byte("<!--", 4, idx);
    endcase
  endfunction

  function automatic logic [7:0] blk_close_byte(input int kind, input int idx);
    case (kind)
      BLK_SCRIPT: return str_byte("</script>", 9, idx);
      BLK_STYLE:  return str_byte("</style>", 8, idx);
      default:    return str_byte("-->", 3, idx);
    endcase
  endfunction

  function automatic logic [7:0] amp_byte(input int idx);
    return str_byte("&amp;", AMP_LEN, idx);
  endfunction

  function automatic int ent_len(input int e);
    case (e)
      0:       return 4;
      1:       return 4;
      2:       return 6;
      3:       return 5;
      4:       return 6;
      default: return 6;
    endcase
  endfunction

  function automatic logic [7:0] ent_byte(input int e, input int idx);
    case (e)
      0:       return str_byte("&lt;", 4, idx);
      1:       return str_byte("&gt;", 4, idx);
      2:       return str_byte("&quot;", 6, idx);
      3:       return str_byte("&#39;", 5, idx);
      4:       return str_byte("&apos;", 6, idx);
      default: return str_byte("&nbsp;", 6, idx);
    endcase
  endfunction

  function automatic logic [7:0] ent_char(input int e);
    case (e)
      0:       return CH_LT;
      1:       return CH_GT;
      2:       return 8'h22;
      3:       return 8'h27;
      4:       return 8'h27;
      default: return CH_SP;
    endcase
  endfunction

  function automatic logic [7:0] fold_lower(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + CASE_OFS : c;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == CH_SP || c == CH_TAB || c == CH_LF || c == CH_CR || c == CH_FF ||
           c == CH_VT;
  endfunction

  function automatic logic is_cont(input logic [7:0] c);
    return (c & UTF8_MASK) == UTF8_CONT;
  endfunction

endpackage

// ===== design/h2t_if.sv =====
// ----------------------------------------------------------------------------
// h2t_in_if / h2t_out_if
// Valid/ready channels for raw document bytes and plain text results.
// ----------------------------------------------------------------------------
interface h2t_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       last_byte;

  modport source (output valid, output text_byte, output last_byte, input ready);
  modport sink (input valid, input text_byte, input last_byte, output ready);
endinterface

interface h2t_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       last_result;

  modport source (output valid, output out_byte, output byte_valid, output last_result,
                  input ready);
  modport sink (input valid, input out_byte, input byte_valid, input last_result,
                output ready);
endinterface

// ===== design/html_to_text_filter.sv =====
// ----------------------------------------------------------------------------
// html_to_text_filter
// HTML byte stream in, plain text byte stream out.
// ----------------------------------------------------------------------------
// The filter takes one document byte per cycle and sends one text byte per
// cycle, when neither side stalls, through a chain of stages (script, style,
// comment, tag, ampersand, entity, whitespace, cut), each ending in a small
// output buffer. A stage that must send n words for a byte holds its input
// until they drain: up to seven at a block opener, ENTITY_HOLD_DEPTH at an
// entity and six at the cut. A byte marked last is followed by an eod token.
// max_length is written through cfg_we/cfg_wdata; the user must do so only
// while the filter is idle, and the value is kept across documents.
// ----------------------------------------------------------------------------
module html_to_text_filter
  import h2t_pkg::*;
#(
  parameter int ENTITY_HOLD_DEPTH = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  h2t_in_if.sink      in_ch,
  h2t_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  localparam int NS = 9;

  logic [15:0] max_len_r;
  logic        sv [NS];
  logic        sr [NS];
  tok_t        stok [NS];
  tok_t        split_tok [2];
  logic [1:0]  split_cnt;
  logic        split_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RST;
    end else if (cfg_we) begin
      max_len_r <= cfg_wdata;
    end
  end

  assign in_ch.ready  = split_ok;
  assign split_tok[0] = '{data: in_ch.text_byte, eod: 1'b0, fin: in_ch.last_byte};
  assign split_tok[1] = '{data: '0, eod: 1'b1, fin: 1'b1};
  assign split_cnt    = in_ch.last_byte ? 2'd2 : 2'd1;

  h2t_emit_buf #(.DEPTH(2)) u_split (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (in_ch.valid && split_ok),
    .load_cnt (split_cnt),
    .load_tok (split_tok),
    .can_load (split_ok),
    .out_valid(sv[0]),
    .out_ready(sr[0]),
    .out_tok  (stok[0])
  );

  h2t_block_stage #(.KIND(BLK_SCRIPT)) u_script (
    .clk(clk), .rst_n(rst_n),
    .in_valid(sv[0]), .in_ready(sr[0]), .in_tok(stok[0]),
    .out_valid(sv[1]), .out_ready(sr[1]), .out_tok(stok[1])
  );

  h2t_block_stage #(.KIND(BLK_STYLE)) u_style (
    .clk(clk), .rst_n(rst_n),
    .in_valid(sv[1]), .in_ready(sr[1]), .in_tok(stok[1]),
    .out_valid(sv[2]), .out_ready(sr[2]), .out_tok(stok[2])
  );

  h2t_block_stage #(.KIND(BLK_COMMENT)) u_comment (
    .clk(clk), .rst_n(rst_n),
    .in_valid(sv[2]), .in_ready(sr[2]), .in_tok(stok[2]),
    .out_valid(sv[3]), .out_ready(sr[3]), .out_tok(stok[3])
  );

  h2t_tag_stage u_tag (
    .clk(clk), .rst_n(rst_n),
    .in_valid(sv[3]), .in_ready(sr[3]), .in_tok(stok[3]),
    .out_valid(sv[4]), .out_ready(sr[4]), .out_tok(stok[4])
  );

  h2t_amp_stage u_amp (
    .clk(clk), .rst_n(rst_n),
    .in_valid(sv[4]), .in_ready(sr[4]), .in_tok(stok[4]),
    .out_valid(sv[5]), .out_ready(sr[5]), .out_tok(stok[5])
  );

  h2t_entity_stage #(.DEPTH(ENTITY_HOLD_DEPTH)) u_entity (
    .clk(clk), .rst_n(rst_n),
    .in_valid(sv[5]), .in_ready(sr[5]), .in_tok(stok[5]),
    .out_valid(sv[6]), .out_ready(sr[6]), .out_tok(stok[6])
  );

  h2t_space_stage u_space (
    .clk(clk), .rst_n(rst_n),
    .in_valid(sv[6]), .in_ready(sr[6]), .in_tok(stok[6]),
    .out_valid(sv[7]), .out_ready(sr[7]), .out_tok(stok[7])
  );

  h2t_cut_stage u_cut (
    .clk(clk), .rst_n(rst_n), .max_len(max_len_r),
    .in_valid(sv[7]), .in_ready(sr[7]), .in_tok(stok[7]),
    .out_valid(sv[8]), .out_ready(sr[8]), .out_tok(stok[8])
  );

  h2t_out_stage u_out (
    .clk(clk), .rst_n(rst_n),
    .in_valid(sv[8]), .in_ready(sr[8]), .in_tok(stok[8]),
    .out_ch(out_ch)
  );

endmodule

// ===== design/h2t_emit_buf.sv =====
// ----------------------------------------------------------------------------
// h2t_emit_buf
// Parallel-load, serial-drain word buffer at the output of each stage.
// ----------------------------------------------------------------------------
module h2t_emit_buf
  import h2t_pkg::*;
#(
  parameter int DEPTH = 8,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  logic [CW-1:0] load_cnt,
  input  tok_t          load_tok [DEPTH],
  output logic          can_load,
  output logic          out_valid,
  input  logic          out_ready,
  output tok_t          out_tok
);

  tok_t          slot_r [DEPTH];
  logic [CW-1:0] cnt_r;
  logic          pop;

  assign out_valid = cnt_r != '0;
  assign out_tok   = slot_r[0];
  assign pop       = out_valid && out_ready;
  assign can_load  = (cnt_r == '0) || (cnt_r == CW'(1) && out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= load_cnt;
    end else if (pop) begin
      cnt_r <= cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot_r <= load_tok;
    end else if (pop) begin
      for (int i = 0; i < DEPTH - 1; i++) slot_r[i] <= slot_r[i+1];
    end
  end

endmodule

// ===== design/h2t_block_stage.sv =====
// ----------------------------------------------------------------------------
// h2t_block_stage
// Drop one kind of block (script, style or comment) from the byte stream.
// ----------------------------------------------------------------------------
module h2t_block_stage
  import h2t_pkg::*;
#(
  parameter int KIND = 0
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  tok_t in_tok,
  output logic out_valid,
  input  logic out_ready,
  output tok_t out_tok
);

  localparam int OL = blk_open_len(KIND);
  localparam int CL = blk_close_len(KIND);
  localparam int CS = blk_close_start(KIND);
  localparam int BD = BLK_HOLD;
  localparam int CW = $clog2(BD + 1);

  logic [3:0]    st_r, st_nxt;
  logic [7:0]    hold_r [BLK_HOLD];
  logic          hold_we;
  logic [2:0]    hold_idx;
  logic [7:0]    lc;
  logic [3:0]    j;
  logic [3:0]    nheld;
  logic          tail_en;
  tok_t          tail;
  tok_t          lt [BD];
  logic [CW-1:0] lcnt;
  logic          can_load, acc;

  assign in_ready = can_load;
  assign acc      = in_valid && can_load;

  always_comb begin
    lc       = fold_lower(in_tok.data);
    st_nxt   = st_r;
    hold_we  = 1'b0;
    hold_idx = '0;
    nheld    = '0;
    tail_en  = 1'b0;
    tail     = in_tok;
    j        = st_r - 4'(OL);
    if (j >= 4'(CL)) j = '0;
    if (in_tok.eod) begin
      nheld   = (st_r < 4'(OL)) ? st_r : '0;
      tail_en = 1'b1;
      st_nxt  = '0;
    end else if (st_r < 4'(OL)) begin
      if (lc == blk_open_byte(KIND, int'(st_r))) begin
        hold_we  = 1'b1;
        hold_idx = st_r[2:0];
        st_nxt   = (st_r == 4'(OL - 1)) ? 4'(OL + CS) : st_r + 4'd1;
      end else begin
        nheld = st_r;
        if (lc == blk_open_byte(KIND, 0)) begin
          hold_we = 1'b1;
          st_nxt  = 4'd1;
        end else begin
          st_nxt  = '0;
          tail_en = 1'b1;
        end
      end
    end else begin
      if (lc == blk_close_byte(KIND, int'(j))) begin
        st_nxt = (j == 4'(CL - 1)) ? '0 : 4'(OL) + j + 4'd1;
      end else if (KIND == BLK_COMMENT && j == 4'd2 && lc == CH_DASH) begin
        st_nxt = 4'(OL + 2);
      end else begin
        st_nxt = (lc == blk_close_byte(KIND, 0)) ? 4'(OL + 1) : 4'(OL);
      end
    end
    for (int i = 0; i < BD; i++) begin
      if (i < int'(nheld)) lt[i] = '{data: hold_r[i], eod: 1'b0, fin: in_tok.fin};
      else lt[i] = tail;
    end
    lcnt = CW'(nheld) + CW'(tail_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (acc) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && hold_we) hold_r[hold_idx] <= in_tok.data;
  end

  h2t_emit_buf #(.DEPTH(BD)) u_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (acc),
    .load_cnt (lcnt),
    .load_tok (lt),
    .can_load (can_load),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_tok  (out_tok)
  );

endmodule

// ===== design/h2t_tag_stage.sv =====
// ----------------------------------------------------------------------------
// h2t_tag_stage
// Drop markup from '<' through '>' and any stray '>'.
// ----------------------------------------------------------------------------
module h2t_tag_stage
  import h2t_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  tok_t in_tok,
  output logic out_valid,
  input  logic out_ready,
  output tok_t out_tok
);

  logic inside_r, inside_nxt;
  logic emit;
  tok_t lt [1];
  logic can_load, acc;

  assign in_ready = can_load;
  assign acc      = in_valid && can_load;
  assign lt[0]    = in_tok;

  always_comb begin
    inside_nxt = inside_r;
    emit       = 1'b0;
    if (in_tok.eod) begin
      inside_nxt = 1'b0;
      emit       = 1'b1;
    end else if (in_tok.data == CH_LT) begin
      inside_nxt = 1'b1;
    end else if (in_tok.data == CH_GT) begin
      inside_nxt = 1'b0;
    end else begin
      emit = !inside_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r <= 1'b0;
    end else if (acc) begin
      inside_r <= inside_nxt;
    end
  end

  h2t_emit_buf #(.DEPTH(1)) u_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (acc),
    .load_cnt (emit),
    .load_tok (lt),
    .can_load (can_load),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_tok  (out_tok)
  );

endmodule

// ===== design/h2t_amp_stage.sv =====
// ----------------------------------------------------------------------------
// h2t_amp_stage
// Decode the ampersand entity ahead of the other entities.
// ----------------------------------------------------------------------------
module h2t_amp_stage
  import h2t_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  tok_t in_tok,
  output logic out_valid,
  input  logic out_ready,
  output tok_t out_tok
);

  localparam int BD = AMP_LEN;
  localparam int CW = $clog2(BD + 1);

  logic [2:0]    prog_r, prog_nxt;
  logic [2:0]    nheld;
  logic          tail_en;
  tok_t          tail;
  tok_t          lt [BD];
  logic [CW-1:0] lcnt;
  logic          can_load, acc;

  assign in_ready = can_load;
  assign acc      = in_valid && can_load;

  always_comb begin
    prog_nxt = prog_r;
    nheld    = '0;
    tail_en  = 1'b0;
    tail     = in_tok;
    if (in_tok.eod) begin
      nheld    = prog_r;
      tail_en  = 1'b1;
      prog_nxt = '0;
    end else if (in_tok.data == amp_byte(int'(prog_r))) begin
      if (prog_r == 3'(AMP_LEN - 1)) begin
        tail_en   = 1'b1;
        tail.data = CH_AMP;
        prog_nxt  = '0;
      end else begin
        prog_nxt = prog_r + 3'd1;
      end
    end else begin
      nheld = prog_r;
      if (in_tok.data == CH_AMP) begin
        prog_nxt = 3'd1;
      end else begin
        prog_nxt = '0;
        tail_en  = 1'b1;
      end
    end
    for (int i = 0; i < BD; i++) begin
      if (i < int'(nheld)) lt[i] = '{data: amp_byte(i), eod: 1'b0, fin: in_tok.fin};
      else lt[i] = tail;
    end
    lcnt = CW'(nheld) + CW'(tail_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prog_r <= '0;
    end else if (acc) begin
      prog_r <= prog_nxt;
    end
  end

  h2t_emit_buf #(.DEPTH(BD)) u_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (acc),
    .load_cnt (lcnt),
    .load_tok (lt),
    .can_load (can_load),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_tok  (out_tok)
  );

endmodule

// ===== design/h2t_entity_stage.sv =====
// ----------------------------------------------------------------------------
// h2t_entity_stage
// Decode the named entities lt, gt, quot, apos, nbsp and the numeric entity &#39;.
// ----------------------------------------------------------------------------
module h2t_entity_stage
  import h2t_pkg::*;
#(
  parameter int DEPTH = 10
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  tok_t in_tok,
  output logic out_valid,
  input  logic out_ready,
  output tok_t out_tok
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [IW-1:0] fill_r, fill_nxt;
  logic [7:0]    hold_r [DEPTH];
  logic          hold_we;
  logic [IW-1:0] hold_idx;
  logic [NUM_ENT-1:0] m;
  logic          full, prefix;
  logic [7:0]    full_ch;
  logic [7:0]    b;
  logic [IW-1:0] nheld;
  logic          tail_en;
  tok_t          tail;
  tok_t          lt [DEPTH];
  logic [CW-1:0] lcnt;
  logic          can_load, acc;

  assign in_ready = can_load;
  assign acc      = in_valid && can_load;

  always_comb begin
    full    = 1'b0;
    prefix  = 1'b0;
    full_ch = '0;
    b       = '0;
    for (int e = 0; e < NUM_ENT; e++) begin
      m[e] = ent_len(e) > int'(fill_r);
      for (int i = 0; i < ENT_MAXLEN; i++) begin
        if (i <= int'(fill_r)) begin
          b = (i == int'(fill_r)) ? in_tok.data : hold_r[i];
          if (b != ent_byte(e, i)) m[e] = 1'b0;
        end
      end
    end
    for (int e = NUM_ENT - 1; e >= 0; e--) begin
      if (m[e] && ent_len(e) == int'(fill_r) + 1) begin
        full    = 1'b1;
        full_ch = ent_char(e);
      end
      if (m[e] && ent_len(e) != int'(fill_r) + 1) prefix = 1'b1;
    end

    fill_nxt = fill_r;
    hold_we  = 1'b0;
    hold_idx = fill_r;
    nheld    = '0;
    tail_en  = 1'b0;
    tail     = in_tok;
    if (in_tok.eod) begin
      nheld    = fill_r;
      tail_en  = 1'b1;
      fill_nxt = '0;
    end else if (fill_r == '0) begin
      if (in_tok.data == CH_AMP) begin
        hold_we  = 1'b1;
        hold_idx = '0;
        fill_nxt = IW'(1);
      end else begin
        tail_en = 1'b1;
      end
    end else if (full) begin
      fill_nxt  = '0;
      tail_en   = 1'b1;
      tail.data = full_ch;
    end else if (prefix && int'(fill_r) + 1 < DEPTH) begin
      hold_we  = 1'b1;
      fill_nxt = fill_r + IW'(1);
    end else begin
      nheld = fill_r;
      if (in_tok.data == CH_AMP) begin
        hold_we  = 1'b1;
        hold_idx = '0;
        fill_nxt = IW'(1);
      end else begin
        fill_nxt = '0;
        tail_en  = 1'b1;
      end
    end
    for (int i = 0; i < DEPTH; i++) begin
      if (i < int'(nheld)) lt[i] = '{data: hold_r[i], eod: 1'b0, fin: in_tok.fin};
      else lt[i] = tail;
    end
    lcnt = CW'(nheld) + CW'(tail_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (acc) begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && hold_we) hold_r[hold_idx] <= in_tok.data;
  end

  h2t_emit_buf #(.DEPTH(DEPTH)) u_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (acc),
    .load_cnt (lcnt),
    .load_tok (lt),
    .can_load (can_load),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_tok  (out_tok)
  );

endmodule

// ===== design/h2t_space_stage.sv =====
// ----------------------------------------------------------------------------
// h2t_space_stage
// Fold whitespace runs into one space and trim both ends.
// ----------------------------------------------------------------------------
module h2t_space_stage
  import h2t_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  tok_t in_tok,
  output logic out_valid,
  input  logic out_ready,
  output tok_t out_tok
);

  logic       pend_r, pend_nxt;
  logic       start_r, start_nxt;
  tok_t       lt [2];
  logic [1:0] lcnt;
  logic       can_load, acc;

  assign in_ready = can_load;
  assign acc      = in_valid && can_load;

  always_comb begin
    pend_nxt  = pend_r;
    start_nxt = start_r;
    lt[0]     = in_tok;
    lt[1]     = in_tok;
    lcnt      = '0;
    if (in_tok.eod) begin
      pend_nxt  = 1'b0;
      start_nxt = 1'b0;
      lcnt      = 2'd1;
    end else if (is_space(in_tok.data)) begin
      if (start_r) pend_nxt = 1'b1;
    end else begin
      pend_nxt  = 1'b0;
      start_nxt = 1'b1;
      if (pend_r) begin
        lt[0].data = CH_SP;
        lcnt       = 2'd2;
      end else begin
        lcnt = 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= 1'b0;
      start_r <= 1'b0;
    end else if (acc) begin
      pend_r  <= pend_nxt;
      start_r <= start_nxt;
    end
  end

  h2t_emit_buf #(.DEPTH(2)) u_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (acc),
    .load_cnt (lcnt),
    .load_tok (lt),
    .can_load (can_load),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_tok  (out_tok)
  );

endmodule

// ===== design/h2t_cut_stage.sv =====
// ----------------------------------------------------------------------------
// h2t_cut_stage
// Cut the text at the length limit on a UTF-8 boundary and append an ellipsis.
// ----------------------------------------------------------------------------
module h2t_cut_stage
  import h2t_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [15:0] max_len,
  input  logic        in_valid,
  output logic        in_ready,
  input  tok_t        in_tok,
  output logic        out_valid,
  input  logic        out_ready,
  output tok_t        out_tok
);

  localparam int BD = 2 * UTF8_HOLD;
  localparam int CW = $clog2(BD + 1);

  logic [16:0]   cnt_r, cnt_nxt;
  logic [7:0]    h_r [UTF8_HOLD];
  logic [1:0]    fill_r, fill_nxt;
  logic          done_r, done_nxt;
  logic          hold_we, hold_shift;
  logic          below, near;
  logic          trim;
  logic [1:0]    ftrim;
  logic [1:0]    nheld, ntail;
  tok_t          tail [UTF8_HOLD];
  tok_t          lt [BD];
  logic [2:0]    tidx;
  logic [CW-1:0] lcnt;
  logic          can_load, acc;

  assign in_ready = can_load;
  assign acc      = in_valid && can_load;
  assign below    = cnt_r < {1'b0, max_len};
  assign near     = ({1'b0, cnt_r} + 18'd3) >= {2'b00, max_len};

  always_comb begin
    ftrim = fill_r;
    trim  = is_cont(in_tok.data);
    for (int t = 0; t < UTF8_HOLD; t++) begin
      if (trim && ftrim != '0 && is_cont(h_r[ftrim - 2'd1])) ftrim = ftrim - 2'd1;
      else trim = 1'b0;
    end
    if (is_cont(in_tok.data) && ftrim != '0) ftrim = ftrim - 2'd1;

    cnt_nxt    = cnt_r;
    fill_nxt   = fill_r;
    done_nxt   = done_r;
    hold_we    = 1'b0;
    hold_shift = 1'b0;
    nheld      = '0;
    ntail      = '0;
    for (int i = 0; i < UTF8_HOLD; i++) tail[i] = in_tok;
    if (in_tok.eod) begin
      nheld    = done_r ? 2'd0 : fill_r;
      ntail    = 2'd1;
      cnt_nxt  = '0;
      fill_nxt = '0;
      done_nxt = 1'b0;
    end else if (done_r) begin
      ntail = '0;
    end else if (below) begin
      cnt_nxt = cnt_r + 17'd1;
      if (fill_r != '0 || near) begin
        if (fill_r == 2'(UTF8_HOLD)) begin
          hold_shift   = 1'b1;
          ntail        = 2'd1;
          tail[0].data = h_r[0];
        end else begin
          hold_we  = 1'b1;
          fill_nxt = fill_r + 2'd1;
        end
      end else begin
        ntail = 2'd1;
      end
    end else begin
      nheld        = ftrim;
      ntail        = 2'd3;
      tail[0].data = ELL_B0;
      tail[1].data = ELL_B1;
      tail[2].data = ELL_B2;
      fill_nxt     = '0;
      done_nxt     = 1'b1;
    end
    for (int i = 0; i < BD; i++) begin
      tidx = 3'(i) - {1'b0, nheld};
      if (i < int'(nheld)) lt[i] = '{data: h_r[i % UTF8_HOLD], eod: 1'b0, fin: in_tok.fin};
      else if (tidx < 3'(UTF8_HOLD)) lt[i] = tail[tidx[1:0]];
      else lt[i] = in_tok;
    end
    lcnt = CW'(nheld) + CW'(ntail);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      fill_r <= '0;
      done_r <= 1'b0;
    end else if (acc) begin
      cnt_r  <= cnt_nxt;
      fill_r <= fill_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && hold_shift) begin
      h_r[0] <= h_r[1];
      h_r[1] <= h_r[2];
      h_r[2] <= in_tok.data;
    end else if (acc && hold_we) begin
      h_r[fill_r] <= in_tok.data;
    end
  end

  h2t_emit_buf #(.DEPTH(BD)) u_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (acc),
    .load_cnt (lcnt),
    .load_tok (lt),
    .can_load (can_load),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_tok  (out_tok)
  );

`ifndef SYNTHESIS
  a_done_empty: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> fill_r == '0)
    else $error("cut stage holds bytes after the ellipsis");
`endif

endmodule

// ===== design/h2t_out_stage.sv =====
// ----------------------------------------------------------------------------
// h2t_out_stage
// Hold back the final document byte to mark it, or send an empty final word.
// ----------------------------------------------------------------------------
module h2t_out_stage
  import h2t_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  tok_t in_tok,
  h2t_out_if.source out_ch
);

  logic       ov_r, ov_nxt;
  logic       hv_r, hv_nxt;
  logic [7:0] hb_r, hb_nxt;
  logic [7:0] ob_r, ob_nxt;
  logic       obv_r, obv_nxt;
  logic       ol_r, ol_nxt;
  logic       acc;

  assign in_ready           = !ov_r || out_ch.ready;
  assign acc                = in_valid && in_ready;
  assign out_ch.valid       = ov_r;
  assign out_ch.out_byte    = ob_r;
  assign out_ch.byte_valid  = obv_r;
  assign out_ch.last_result = ol_r;

  always_comb begin
    ov_nxt  = ov_r && !out_ch.ready;
    hv_nxt  = hv_r;
    hb_nxt  = hb_r;
    ob_nxt  = ob_r;
    obv_nxt = obv_r;
    ol_nxt  = ol_r;
    if (acc) begin
      if (in_tok.eod) begin
        ov_nxt  = 1'b1;
        ob_nxt  = hv_r ? hb_r : '0;
        obv_nxt = hv_r;
        ol_nxt  = 1'b1;
        hv_nxt  = 1'b0;
      end else if (!in_tok.fin) begin
        ov_nxt  = 1'b1;
        ob_nxt  = in_tok.data;
        obv_nxt = 1'b1;
        ol_nxt  = 1'b0;
      end else begin
        if (hv_r) begin
          ov_nxt  = 1'b1;
          ob_nxt  = hb_r;
          obv_nxt = 1'b1;
          ol_nxt  = 1'b0;
        end
        hv_nxt = 1'b1;
        hb_nxt = in_tok.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      hv_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
      hv_r <= hv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hb_r  <= hb_nxt;
    ob_r  <= ob_nxt;
    obv_r <= obv_nxt;
    ol_r  <= ol_nxt;
  end

`ifndef SYNTHESIS
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.byte_valid |-> out_ch.last_result)
    else $error("empty word without final mark");
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_tok.eod |=> !hv_r && ov_r && ol_r)
    else $error("document end left a byte held");
`endif

endmodule
